// ----- rtl/obsd_pkg.sv -----
// Package for the oriented box signed distance block.
// Holds field widths, register codes, payload structs and saturation helpers.
// Used by every file under rtl but obsd_fifo; depends on nothing.
package obsd_pkg;

    localparam int COORD_W = 20;
    localparam int UNIT_W = 16;
    localparam int UNIT_FRAC = UNIT_W - 2;
    localparam int DIST_W = COORD_W + 2;
    localparam int DIFF_W = COORD_W + 1;
    localparam int PB_W = 26;
    localparam int GAP_W = 27;
    localparam int MAG_W = 25;
    localparam int SUM_W = 50;
    localparam int NORM_EXTRA = 10;
    localparam int NORM_HALF = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 3 * COORD_W;

    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LENGTHS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_ROW_ZERO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_ROW_ONE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_ROW_TWO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_ZERO_LIMIT = 3'd5;

    localparam logic signed [UNIT_W-1:0] UNIT_ONE = UNIT_W'(1 << UNIT_FRAC);

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic signed [UNIT_W-1:0] quat_w;
        logic signed [UNIT_W-1:0] quat_x;
        logic signed [UNIT_W-1:0] quat_y;
        logic signed [UNIT_W-1:0] quat_z;
    } query_t;

    typedef struct packed {
        logic signed [DIST_W-1:0] signed_distance;
        logic signed [UNIT_W-1:0] normal_x;
        logic signed [UNIT_W-1:0] normal_y;
        logic signed [UNIT_W-1:0] normal_z;
    } result_t;

    typedef struct packed {
        logic signed [UNIT_W-1:0] w;
        logic signed [UNIT_W-1:0] x;
        logic signed [UNIT_W-1:0] y;
        logic signed [UNIT_W-1:0] z;
    } quat_t;

    typedef struct packed {
        logic [0:2][COORD_W-1:0] lengths;
        logic [0:2][COORD_W-1:0] offset;
        logic [0:2][0:2][UNIT_W-1:0] axis;
        logic [COORD_W-1:0] limit;
    } cfg_t;

    typedef struct packed {
        logic outside;
        logic [SUM_W-1:0] sum_sq;
        logic [0:2][MAG_W-1:0] rmag;
        logic [0:2] r_neg;
        logic [1:0] face;
        logic face_neg;
        logic signed [DIST_W-1:0] dist_in;
        quat_t quat;
    } mid_t;

    function automatic logic signed [DIST_W-1:0] sat_dist(input logic signed [31:0] v);
        logic signed [31:0] hi;
        logic signed [31:0] lo;
        logic signed [31:0] c;
        hi = (32'sd1 <<< (DIST_W - 1)) - 32'sd1;
        lo = -hi - 32'sd1;
        c = (v > hi) ? hi : ((v < lo) ? lo : v);
        return c[DIST_W-1:0];
    endfunction

    function automatic logic signed [UNIT_W-1:0] sat_unit(input logic signed [31:0] v);
        logic signed [31:0] hi;
        logic signed [31:0] lo;
        logic signed [31:0] c;
        hi = (32'sd1 <<< (UNIT_W - 1)) - 32'sd1;
        lo = -hi - 32'sd1;
        c = (v > hi) ? hi : ((v < lo) ? lo : v);
        return c[UNIT_W-1:0];
    endfunction

endpackage

// ----- rtl/obsd_fifo.sv -----
// Small first-in first-out queue built from a register array.
// Used between the front and back parts and for the result side; uses no package.
module obsd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW:0] count_reg;
    logic do_push;
    logic do_pop;

    assign full = (count_reg == (AW+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign dout = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/obsd_front.sv -----
// Front part: takes requests, moves the point into the box frame, clamps it
// and decides inside or outside. Depends on obsd_pkg.
module obsd_front (
    input  logic             clk,
    input  logic             rst_n,
    input  obsd_pkg::cfg_t   cfg,
    input  logic             push,
    input  obsd_pkg::query_t query,
    output logic             full,
    input  logic             mid_full,
    output logic             mid_push,
    output obsd_pkg::mid_t   mid_item
);
    import obsd_pkg::*;

    localparam int STAGES = 5;
    localparam int PROD_W = UNIT_W + DIFF_W;
    localparam int ACC_W = PROD_W + 2;

    logic [STAGES-1:0] vld_reg;
    logic adv;

    logic signed [COORD_W-1:0] pt [3];
    logic signed [DIFF_W-1:0] d_reg [3];
    logic signed [PROD_W-1:0] prod_reg [3][3];
    logic signed [ACC_W-1:0] acc [3];
    logic signed [GAP_W-1:0] pbx [3];
    logic signed [GAP_W-1:0] hx [3];
    logic signed [GAP_W-1:0] cl [3];
    logic signed [PB_W-1:0] r_reg [3];
    logic signed [GAP_W-1:0] g_reg [3];
    logic [2:0] pbneg_reg;
    logic signed [PB_W-1:0] rabs [3];
    logic [MAG_W-1:0] rmag_reg [3];
    logic [2:0] rneg_reg;
    logic [2*MAG_W-1:0] sq_reg [3];
    logic [COORD_W:0] lim2;
    logic [2*COORD_W+1:0] lim_sq_reg;
    logic [1:0] face;
    logic [1:0] face_reg;
    logic face_neg_reg;
    logic signed [GAP_W-1:0] gk;
    logic signed [DIST_W-1:0] dist_in_reg;
    logic [SUM_W-1:0] sum_sq;
    quat_t q1_reg;
    quat_t q2_reg;
    quat_t q3_reg;
    quat_t q4_reg;
    mid_t mid_reg;

    assign adv = !(vld_reg[STAGES-1] && mid_full);
    assign full = !adv;
    assign mid_push = vld_reg[STAGES-1] && adv;
    assign mid_item = mid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], push};
        end
    end

    always_comb
    begin
        pt[0] = query.point_x;
        pt[1] = query.point_y;
        pt[2] = query.point_z;
        for (int i = 0; i < 3; i++)
        begin
            acc[i] = ACC_W'(prod_reg[i][0]) + ACC_W'(prod_reg[i][1])
                   + ACC_W'(prod_reg[i][2]);
            pbx[i] = GAP_W'((acc[i] + ACC_W'(1 << (UNIT_FRAC - 2))) >>> (UNIT_FRAC - 1));
            hx[i] = GAP_W'($signed({1'b0, cfg.lengths[i]}));
            if (pbx[i] > hx[i])
            begin
                cl[i] = hx[i];
            end
            else if (pbx[i] < -hx[i])
            begin
                cl[i] = -hx[i];
            end
            else
            begin
                cl[i] = pbx[i];
            end
            rabs[i] = r_reg[i][PB_W-1] ? -r_reg[i] : r_reg[i];
        end
        face = 2'd0;
        if (g_reg[1] < g_reg[0])
        begin
            face = 2'd1;
        end
        gk = (face == 2'd1) ? g_reg[1] : g_reg[0];
        if (g_reg[2] < gk)
        begin
            face = 2'd2;
            gk = g_reg[2];
        end
        lim2 = {cfg.limit, 1'b0};
        sum_sq = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d_reg[i] <= DIFF_W'(pt[i]) - DIFF_W'($signed(cfg.offset[i]));
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[i][j] <= $signed(cfg.axis[j][i]) * d_reg[j];
                end
                r_reg[i] <= PB_W'(pbx[i] - cl[i]);
                g_reg[i] <= hx[i] - (pbx[i][GAP_W-1] ? -pbx[i] : pbx[i]);
                pbneg_reg[i] <= pbx[i][GAP_W-1];
                rmag_reg[i] <= MAG_W'(rabs[i]);
                rneg_reg[i] <= r_reg[i][PB_W-1];
                sq_reg[i] <= MAG_W'(rabs[i]) * MAG_W'(rabs[i]);
            end
            q1_reg <= '{query.quat_w, query.quat_x, query.quat_y, query.quat_z};
            q2_reg <= q1_reg;
            q3_reg <= q2_reg;
            q4_reg <= q3_reg;
            lim_sq_reg <= lim2 * lim2;
            face_reg <= face;
            face_neg_reg <= pbneg_reg[face];
            dist_in_reg <= sat_dist((32'sd1 - 32'(gk)) >>> 1);
            mid_reg.outside <= sum_sq > SUM_W'(lim_sq_reg);
            mid_reg.sum_sq <= sum_sq;
            for (int i = 0; i < 3; i++)
            begin
                mid_reg.rmag[i] <= rmag_reg[i];
                mid_reg.r_neg[i] <= rneg_reg[i];
            end
            mid_reg.face <= face_reg;
            mid_reg.face_neg <= face_neg_reg;
            mid_reg.dist_in <= dist_in_reg;
            mid_reg.quat <= q4_reg;
        end
    end

endmodule

// ----- rtl/obsd_back.sv -----
// Back part: residual norm, normal division, inside/outside selection and the
// two rotations of the normal into the world frame. Depends on obsd_pkg.
module obsd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  obsd_pkg::cfg_t    cfg,
    input  logic              mid_empty,
    input  obsd_pkg::mid_t    mid_head,
    output logic              mid_pop,
    input  logic              out_full,
    output logic              out_push,
    output obsd_pkg::result_t out_item
);
    import obsd_pkg::*;

    localparam int XW = SUM_W + NORM_EXTRA;
    localparam int SQ_STEPS = XW / 2;
    localparam int ROOT_W = SQ_STEPS;
    localparam int REM_W = ROOT_W + 2;
    localparam int QUO_W = UNIT_FRAC + 1;
    localparam int NUM_W = MAG_W + UNIT_FRAC + NORM_HALF + 1;
    localparam int BD = SQ_STEPS + QUO_W + 9;
    localparam int MW = UNIT_W + 4;
    localparam int AMS_W = 2 * UNIT_W + 2;
    localparam int CP_W = UNIT_W + MW;
    localparam int TW = 24;
    localparam int CT_W = UNIT_W + TW;

    typedef struct packed {
        logic outside;
        logic [0:2] r_neg;
        logic [1:0] face;
        logic face_neg;
        logic signed [DIST_W-1:0] dist_in;
        quat_t quat;
    } meta_t;

    typedef struct packed {
        logic [XW-1:0] x;
        logic [REM_W-1:0] rem;
        logic [ROOT_W-1:0] root;
        logic [0:2][MAG_W-1:0] rmag;
        meta_t meta;
    } sq_t;

    typedef struct packed {
        logic [0:2][NUM_W-1:0] num;
        logic [0:2][QUO_W-1:0] quo;
        logic [ROOT_W-1:0] root;
        meta_t meta;
    } dv_t;

    logic [BD-1:0] vld_reg;
    logic adv;

    sq_t sq_reg [SQ_STEPS+1];
    dv_t dv_reg [QUO_W+1];

    logic signed [UNIT_W-1:0] n_sel [3];
    logic signed [UNIT_W-1:0] n_reg [3];
    logic signed [UNIT_W-1:0] qmag [3];
    logic [ROOT_W:0] dist_o;
    logic signed [DIST_W-1:0] dist_sel;
    logic signed [2*UNIT_W-1:0] am_reg [3][3];
    logic signed [AMS_W-1:0] am_sum [3];
    logic signed [MW-1:0] m_reg [3];
    logic signed [MW-1:0] m1_reg [3];
    logic signed [MW-1:0] m2_reg [3];
    logic signed [MW-1:0] m3_reg [3];
    logic signed [CP_W-1:0] cp_reg [3][2];
    logic signed [CP_W:0] cdiff [3];
    logic signed [TW-1:0] t_reg [3];
    logic signed [CT_W-1:0] wt_reg [3];
    logic signed [CT_W-1:0] ct_reg [3][2];
    logic signed [CT_W:0] c2d [3];
    logic signed [31:0] o_sum [3];
    logic signed [DIST_W-1:0] dist_reg [6];
    quat_t q_reg [5];
    result_t res_reg;
    meta_t head_meta;

    assign adv = !(vld_reg[BD-1] && out_full);
    assign mid_pop = adv && !mid_empty;
    assign out_push = vld_reg[BD-1] && adv;
    assign out_item = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[BD-2:0], mid_pop};
        end
    end

    always_comb
    begin
        head_meta.outside = mid_head.outside;
        head_meta.r_neg = mid_head.r_neg;
        head_meta.face = mid_head.face;
        head_meta.face_neg = mid_head.face_neg;
        head_meta.dist_in = mid_head.dist_in;
        head_meta.quat = mid_head.quat;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg[0].x <= {mid_head.sum_sq, NORM_EXTRA'(0)};
            sq_reg[0].rem <= '0;
            sq_reg[0].root <= '0;
            sq_reg[0].rmag <= mid_head.rmag;
            sq_reg[0].meta <= head_meta;
        end
    end

    for (genvar s = 0; s < SQ_STEPS; s++)
    begin : g_sqrt
        logic [REM_W+1:0] rem_sh;
        logic [REM_W+1:0] trial;
        sq_t nxt;
        always_comb
        begin
            nxt = sq_reg[s];
            rem_sh = {sq_reg[s].rem, sq_reg[s].x[XW-1 -: 2]};
            trial = (REM_W+2)'({sq_reg[s].root, 2'b01});
            nxt.x = sq_reg[s].x << 2;
            if (rem_sh >= trial)
            begin
                nxt.rem = REM_W'(rem_sh - trial);
                nxt.root = {sq_reg[s].root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                nxt.rem = REM_W'(rem_sh);
                nxt.root = {sq_reg[s].root[ROOT_W-2:0], 1'b0};
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_reg[s+1] <= nxt;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dv_reg[0].num[i] <= (NUM_W'(sq_reg[SQ_STEPS].rmag[i]) << (UNIT_FRAC + NORM_HALF))
                                  + NUM_W'(sq_reg[SQ_STEPS].root >> 1);
            end
            dv_reg[0].quo <= '0;
            dv_reg[0].root <= sq_reg[SQ_STEPS].root;
            dv_reg[0].meta <= sq_reg[SQ_STEPS].meta;
        end
    end

    for (genvar d = 0; d < QUO_W; d++)
    begin : g_div
        logic [NUM_W-1:0] dsh;
        dv_t nxt;
        always_comb
        begin
            nxt = dv_reg[d];
            dsh = NUM_W'(dv_reg[d].root) << (QUO_W - 1 - d);
            for (int i = 0; i < 3; i++)
            begin
                if (dv_reg[d].num[i] >= dsh)
                begin
                    nxt.num[i] = dv_reg[d].num[i] - dsh;
                    nxt.quo[i] = {dv_reg[d].quo[i][QUO_W-2:0], 1'b1};
                end
                else
                begin
                    nxt.quo[i] = {dv_reg[d].quo[i][QUO_W-2:0], 1'b0};
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_reg[d+1] <= nxt;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qmag[i] = $signed({1'b0, dv_reg[QUO_W].quo[i]});
            if (dv_reg[QUO_W].meta.outside)
            begin
                n_sel[i] = dv_reg[QUO_W].meta.r_neg[i] ? -qmag[i] : qmag[i];
            end
            else if (dv_reg[QUO_W].meta.face == 2'(i))
            begin
                n_sel[i] = dv_reg[QUO_W].meta.face_neg ? -UNIT_ONE : UNIT_ONE;
            end
            else
            begin
                n_sel[i] = '0;
            end
        end
        dist_o = (ROOT_W+1)'(dv_reg[QUO_W].root) + (ROOT_W+1)'(1 << NORM_HALF);
        dist_sel = dv_reg[QUO_W].meta.outside
                 ? sat_dist(32'($signed({1'b0, dist_o >> (NORM_HALF + 1)})))
                 : dv_reg[QUO_W].meta.dist_in;
        for (int i = 0; i < 3; i++)
        begin
            am_sum[i] = AMS_W'(am_reg[i][0]) + AMS_W'(am_reg[i][1]) + AMS_W'(am_reg[i][2]);
        end
        cdiff[0] = (CP_W+1)'(cp_reg[0][0]) - (CP_W+1)'(cp_reg[0][1]);
        cdiff[1] = (CP_W+1)'(cp_reg[1][0]) - (CP_W+1)'(cp_reg[1][1]);
        cdiff[2] = (CP_W+1)'(cp_reg[2][0]) - (CP_W+1)'(cp_reg[2][1]);
        for (int i = 0; i < 3; i++)
        begin
            c2d[i] = (CT_W+1)'(ct_reg[i][0]) - (CT_W+1)'(ct_reg[i][1]);
            o_sum[i] = 32'(m3_reg[i])
                     + 32'((wt_reg[i] + CT_W'(1 << (UNIT_FRAC - 1))) >>> UNIT_FRAC)
                     + 32'((c2d[i] + (CT_W+1)'(1 << (UNIT_FRAC - 1))) >>> UNIT_FRAC);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                n_reg[i] <= n_sel[i];
                for (int j = 0; j < 3; j++)
                begin
                    am_reg[i][j] <= $signed(cfg.axis[i][j]) * n_reg[j];
                end
                m_reg[i] <= MW'((am_sum[i] + AMS_W'(1 << (UNIT_FRAC - 1))) >>> UNIT_FRAC);
                m1_reg[i] <= m_reg[i];
                m2_reg[i] <= m1_reg[i];
                m3_reg[i] <= m2_reg[i];
                t_reg[i] <= TW'((cdiff[i] + (CP_W+1)'(1 << (UNIT_FRAC - 2)))
                                >>> (UNIT_FRAC - 1));
                wt_reg[i] <= q_reg[4].w * t_reg[i];
            end
            cp_reg[0][0] <= q_reg[2].y * m_reg[2];
            cp_reg[0][1] <= q_reg[2].z * m_reg[1];
            cp_reg[1][0] <= q_reg[2].z * m_reg[0];
            cp_reg[1][1] <= q_reg[2].x * m_reg[2];
            cp_reg[2][0] <= q_reg[2].x * m_reg[1];
            cp_reg[2][1] <= q_reg[2].y * m_reg[0];
            ct_reg[0][0] <= q_reg[4].y * t_reg[2];
            ct_reg[0][1] <= q_reg[4].z * t_reg[1];
            ct_reg[1][0] <= q_reg[4].z * t_reg[0];
            ct_reg[1][1] <= q_reg[4].x * t_reg[2];
            ct_reg[2][0] <= q_reg[4].x * t_reg[1];
            ct_reg[2][1] <= q_reg[4].y * t_reg[0];
            q_reg[0] <= dv_reg[QUO_W].meta.quat;
            q_reg[1] <= q_reg[0];
            q_reg[2] <= q_reg[1];
            q_reg[3] <= q_reg[2];
            q_reg[4] <= q_reg[3];
            dist_reg[0] <= dist_sel;
            for (int k = 1; k < 6; k++)
            begin
                dist_reg[k] <= dist_reg[k-1];
            end
            res_reg.signed_distance <= dist_reg[5];
            res_reg.normal_x <= sat_unit(o_sum[0]);
            res_reg.normal_y <= sat_unit(o_sum[1]);
            res_reg.normal_z <= sat_unit(o_sum[2]);
        end
    end

endmodule

// ----- rtl/oriented_box_signed_distance.sv -----
// Top level of the oriented box signed distance block.
// Holds the configuration registers and joins front, queues and back; depends on obsd_pkg.
//
// Each request is a point and an orientation quaternion; each gives one result,
// the signed distance to the configured box and the world-frame outward normal.
// A request is taken every cycle while full is low and results are read in
// order through empty and pop. A request passes through the front part, the
// middle queue, the back part and the result queue in that order; the back
// part holds the 30 one-bit steps of the square root and the 15 one-bit steps
// of the normal division, all fully pipelined. Write the configuration only
// while no request is in flight.
module oriented_box_signed_distance #(
    parameter int QUEUE_DEPTH = 4,
    parameter int RESULT_DEPTH = 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [obsd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [obsd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                push,
    output logic                                full,
    input  obsd_pkg::query_t                    query,
    output logic                                empty,
    input  logic                                pop,
    output obsd_pkg::result_t                   result
);
    import obsd_pkg::*;

    cfg_t cfg_reg;
    logic mid_push;
    logic mid_full;
    logic mid_pop;
    logic mid_empty;
    mid_t mid_item;
    mid_t mid_head;
    logic out_push;
    logic out_full;
    result_t out_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lengths <= '0;
            cfg_reg.offset <= '0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    cfg_reg.axis[i][j] <= (i == j) ? UNIT_ONE : '0;
                end
            end
            cfg_reg.limit <= COORD_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BOX_LENGTHS: cfg_reg.lengths <= cfg_data[3*COORD_W-1:0];
                CFG_CENTRE_OFFSET: cfg_reg.offset <= cfg_data[3*COORD_W-1:0];
                CFG_AXIS_ROW_ZERO: cfg_reg.axis[0] <= cfg_data[3*UNIT_W-1:0];
                CFG_AXIS_ROW_ONE: cfg_reg.axis[1] <= cfg_data[3*UNIT_W-1:0];
                CFG_AXIS_ROW_TWO: cfg_reg.axis[2] <= cfg_data[3*UNIT_W-1:0];
                CFG_NEAR_ZERO_LIMIT: cfg_reg.limit <= cfg_data[COORD_W-1:0];
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    obsd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .push     (push),
        .query    (query),
        .full     (full),
        .mid_full (mid_full),
        .mid_push (mid_push),
        .mid_item (mid_item)
    );

    obsd_fifo #(
        .WIDTH ($bits(mid_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .din   (mid_item),
        .full  (mid_full),
        .pop   (mid_pop),
        .dout  (mid_head),
        .empty (mid_empty)
    );

    obsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .mid_empty (mid_empty),
        .mid_head  (mid_head),
        .mid_pop   (mid_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_item  (out_item)
    );

    obsd_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RESULT_DEPTH)
    ) u_result_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .din   (out_item),
        .full  (out_full),
        .pop   (pop),
        .dout  (result),
        .empty (empty)
    );

`ifndef SYNTH
    a_mid_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        mid_push |-> !mid_full)
        else $error("front part pushed into a full middle queue");

    a_mid_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
        mid_pop |-> !mid_empty)
        else $error("back part took a request from an empty middle queue");

    a_out_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("back part pushed into a full result queue");
`endif

endmodule
